// File: src/lpr_pkg.sv
// Package for the line pixel rasterizer: beat types, the job record passed
// from the front end to the walker, widths, defaults and the walker state type.
// Depends on nothing; every other file in src imports it.
package lpr_pkg;

  // Coordinates are fixed at six bits by the beat formats.
  localparam int COORD_W       = 6;
  // Pixel count of a run: up to 2**COORD_W, so one bit more than a coordinate.
  localparam int CNT_W         = COORD_W + 1;
  // Signed Bresenham error term.
  localparam int ERR_W         = 9;
  localparam int TILE_SIZE_DEF = 64;
  localparam int QUEUE_DEPTH   = 2;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
  } seg_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic               last_pixel;
  } pix_t;

  // One classified segment, ready to walk.
  typedef struct packed {
    logic [COORD_W-1:0]      first_x;
    logic [COORD_W-1:0]      first_y;
    logic [COORD_W-1:0]      amaj;
    logic [COORD_W-1:0]      amin;
    logic                    x_major;
    logic                    minor_up;
    logic signed [ERR_W-1:0] err_init;
  } job_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

endpackage

// File: src/lpr_front.sv
// Front end of the line pixel rasterizer: clamps the endpoints, classifies the
// segment (major axis, walk direction, start point, initial error) and
// registers the result as one job. Depends on lpr_pkg.
module lpr_front
  import lpr_pkg::*;
#(
  parameter int TILE_SIZE = TILE_SIZE_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic seg_valid,
  output logic seg_stall,
  input  seg_t seg,
  output logic job_valid,
  input  logic job_ready,
  output job_t job
);

  localparam logic [COORD_W-1:0] MAX_COORD = COORD_W'(TILE_SIZE - 1);

  logic [COORD_W-1:0]      x1, y1, x2, y2;
  logic [COORD_W-1:0]      adx, ady, amaj, amin;
  logic                    xmaj, mup, take_first;
  logic [ERR_W-1:0]        amin_w, amaj_w;
  job_t                    job_next;

  always_comb begin
    x1 = (seg.start_x > MAX_COORD) ? MAX_COORD : seg.start_x;
    y1 = (seg.start_y > MAX_COORD) ? MAX_COORD : seg.start_y;
    x2 = (seg.end_x   > MAX_COORD) ? MAX_COORD : seg.end_x;
    y2 = (seg.end_y   > MAX_COORD) ? MAX_COORD : seg.end_y;
    adx  = (x1 > x2) ? (x1 - x2) : (x2 - x1);
    ady  = (y1 > y2) ? (y1 - y2) : (y2 - y1);
    xmaj = adx > ady;
    // The minor axis climbs when the deltas share a sign or either is zero.
    mup  = ((x2 >= x1) == (y2 >= y1)) || (adx == '0) || (ady == '0);
    amaj = xmaj ? adx : ady;
    amin = xmaj ? ady : adx;
    take_first = xmaj ? (x1 < x2) : (y1 < y2);
    amin_w = {{(ERR_W - COORD_W){1'b0}}, amin};
    amaj_w = {{(ERR_W - COORD_W){1'b0}}, amaj};
    job_next.first_x  = take_first ? x1 : x2;
    job_next.first_y  = take_first ? y1 : y2;
    job_next.amaj     = amaj;
    job_next.amin     = amin;
    job_next.x_major  = xmaj;
    job_next.minor_up = mup;
    job_next.err_init = $signed({amin_w[ERR_W-2:0], 1'b0} - amaj_w);
  end

  assign seg_stall = job_valid && !job_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (seg_valid && !seg_stall) begin
      job_valid <= 1'b1;
    end else if (job_ready) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seg_valid && !seg_stall) begin
      job <= job_next;
    end
  end

endmodule

// File: src/lpr_queue.sv
// Short job queue between the front end and the walker of the line pixel
// rasterizer, held in flip-flops. Depends on lpr_pkg.
module lpr_queue
  import lpr_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic ready,
  input  job_t push_job,
  output logic head_valid,
  input  logic pop,
  output job_t head_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign ready      = count != FULL_CNT;
  assign head_valid = count != '0;
  assign head_job   = slots[rd_ptr];
  assign do_push    = push && ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

`ifndef SYNTHESIS
  // The fill count never runs past the number of slots.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_CNT) else $error("job queue count beyond its depth");
  // The walker only takes a job that is present.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid) else $error("job popped from an empty queue");
`endif

endmodule

// File: src/lpr_back.sv
// Walker of the line pixel rasterizer: takes one job from the queue and
// steps along the major axis one pixel per cycle, while the output is not
// stalled, into a registered output. Depends on lpr_pkg.
module lpr_back
  import lpr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_pop,
  input  job_t q_job,
  output logic pix_valid,
  input  logic pix_stall,
  output pix_t pix
);

  back_state_t             state, state_next;
  logic [COORD_W-1:0]      cur_x, cur_y;
  logic signed [ERR_W-1:0] err, inc_flat, inc_step;
  logic [CNT_W-1:0]        steps_left;
  logic                    x_major, minor_up;
  logic                    emit, last;
  logic [COORD_W-1:0]      minor_delta;
  logic [ERR_W-1:0]        amin_w, amaj_w, diff_w;

  assign last        = steps_left == CNT_W'(1);
  assign minor_delta = minor_up ? COORD_W'(1) : '1;

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (q_valid) state_next = BK_RUN;
      BK_RUN:  if (emit && last) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    emit  = 1'b0;
    unique case (state)
      BK_IDLE: q_pop = q_valid;
      BK_RUN:  emit  = !pix_valid || !pix_stall;
      default: begin
        q_pop = 1'b0;
        emit  = 1'b0;
      end
    endcase
  end

  always_comb begin
    amin_w = {{(ERR_W - COORD_W){1'b0}}, q_job.amin};
    amaj_w = {{(ERR_W - COORD_W){1'b0}}, q_job.amaj};
    diff_w = amin_w - amaj_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_IDLE;
      pix_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        pix_valid <= 1'b1;
      end else if (!pix_stall) begin
        pix_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_x      <= q_job.first_x;
      cur_y      <= q_job.first_y;
      err        <= q_job.err_init;
      steps_left <= {1'b0, q_job.amaj} + CNT_W'(1);
      x_major    <= q_job.x_major;
      minor_up   <= q_job.minor_up;
      inc_flat   <= $signed({amin_w[ERR_W-2:0], 1'b0});
      inc_step   <= $signed({diff_w[ERR_W-2:0], 1'b0});
    end else if (emit) begin
      pix.pixel_x    <= cur_x;
      pix.pixel_y    <= cur_y;
      pix.last_pixel <= last;
      steps_left     <= steps_left - CNT_W'(1);
      if (!err[ERR_W-1]) begin
        err <= err + inc_step;
      end else begin
        err <= err + inc_flat;
      end
      if (x_major) begin
        cur_x <= cur_x + COORD_W'(1);
        if (!err[ERR_W-1]) begin
          cur_y <= cur_y + minor_delta;
        end
      end else begin
        cur_y <= cur_y + COORD_W'(1);
        if (!err[ERR_W-1]) begin
          cur_x <= cur_x + minor_delta;
        end
      end
    end
  end

`ifndef SYNTHESIS
  // A walk in progress always has at least one pixel left to send.
  a_run_has_work: assert property (@(posedge clk) disable iff (rst)
    (state == BK_RUN) |-> (steps_left != '0)) else $error("walker running with no pixels left");
  // Sending the final pixel ends the walk.
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (emit && last) |=> (state == BK_IDLE)) else $error("walker kept running after last pixel");
`endif

endmodule

// File: src/line_pixel_rasterizer.sv
// Top level of the line pixel rasterizer: front end, job queue and walker.
// Depends on lpr_pkg, lpr_front, lpr_queue and lpr_back.
//
// Each input beat carries one line segment as two endpoints inside a tile of
// TILE_SIZE x TILE_SIZE pixels; a coordinate of TILE_SIZE or more is clamped
// to TILE_SIZE - 1. The block answers with one output beat per pixel of the
// Bresenham line, in walk order, with last_pixel set on the final beat. The
// major axis is x when |dx| > |dy| and y otherwise, and the walk starts at the
// endpoint with the smaller major coordinate. The walker first loads a job
// from the queue and then steps one pixel per cycle while the output is not
// stalled; its single step unit sets that rate. The front end classifies the
// next segment and parks it in a two-entry queue while the walker is still
// busy, so input beats are taken while a line is being drawn. The output is
// registered and a stalled pixel beat holds until it is taken.
module line_pixel_rasterizer
  import lpr_pkg::*;
#(
  parameter int TILE_SIZE = TILE_SIZE_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic seg_valid,
  output logic seg_stall,
  input  seg_t seg,
  output logic pix_valid,
  input  logic pix_stall,
  output pix_t pix
);

  logic front_valid, queue_ready, head_valid, head_pop;
  job_t front_job, head_job;

  // Clamp and classify each segment into a job.
  lpr_front #(
    .TILE_SIZE(TILE_SIZE)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .seg_valid(seg_valid),
    .seg_stall(seg_stall),
    .seg      (seg),
    .job_valid(front_valid),
    .job_ready(queue_ready),
    .job      (front_job)
  );

  // Jobs wait here so the front end and walker stall independently.
  lpr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (front_valid),
    .ready     (queue_ready),
    .push_job  (front_job),
    .head_valid(head_valid),
    .pop       (head_pop),
    .head_job  (head_job)
  );

  // Walk the line and emit one pixel beat per cycle unless the output stalls.
  lpr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (head_valid),
    .q_pop    (head_pop),
    .q_job    (head_job),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .pix      (pix)
  );

endmodule

// File: verif/tb_top.sv
// Self-checking testbench for line_pixel_rasterizer: drives line segments,
// predicts each Bresenham pixel run and checks every pixel beat in order.
// Depends on lpr_pkg and the RTL in src; needs no files and no arguments.
module tb_top;
  import lpr_pkg::*;

  localparam int TILE = TILE_SIZE_DEF;

  // Tracks the pixels a rasterizer should produce. Each accepted segment is
  // walked at once and its pixels are queued; each output beat is then
  // matched against the oldest queued pixel.
  class raster_tracker;
    logic [COORD_W-1:0]      cur_x;
    logic [COORD_W-1:0]      cur_y;
    logic signed [ERR_W-1:0] err_term;
    logic [CNT_W-1:0]        steps_left;
    logic [COORD_W-1:0]      abs_dx;
    logic [COORD_W-1:0]      abs_dy;
    logic                    x_major;
    logic                    minor_up;
    pix_t                    pending_pixels[$];
    int                      mismatch_count;

    function new();
      cur_x = '0;
      cur_y = '0;
      err_term = '0;
      steps_left = '0;
      abs_dx = '0;
      abs_dy = '0;
      x_major = 1'b0;
      minor_up = 1'b0;
      mismatch_count = 0;
    endfunction

    // Coordinates at or beyond the tile edge are pulled back onto it.
    function int fit_tile(logic [COORD_W-1:0] v);
      return (int'(v) > TILE - 1) ? TILE - 1 : int'(v);
    endfunction

    function void take_segment(seg_t s);
      int   x1, y1, x2, y2;
      int   amaj, amin;
      pix_t p;
      x1 = fit_tile(s.start_x);
      y1 = fit_tile(s.start_y);
      x2 = fit_tile(s.end_x);
      y2 = fit_tile(s.end_y);
      abs_dx = COORD_W'((x1 > x2) ? x1 - x2 : x2 - x1);
      abs_dy = COORD_W'((y1 > y2) ? y1 - y2 : y2 - y1);
      // The minor axis climbs when dx and dy agree in sign or one is zero.
      minor_up = ((x2 >= x1) == (y2 >= y1)) || abs_dx == 0 || abs_dy == 0;
      x_major = abs_dx > abs_dy;
      if (x_major) begin
        cur_x = COORD_W'((x1 < x2) ? x1 : x2);
        cur_y = COORD_W'((x1 < x2) ? y1 : y2);
        amaj = int'(abs_dx);
        amin = int'(abs_dy);
      end else begin
        cur_x = COORD_W'((y1 < y2) ? x1 : x2);
        cur_y = COORD_W'((y1 < y2) ? y1 : y2);
        amaj = int'(abs_dy);
        amin = int'(abs_dx);
      end
      err_term = ERR_W'(2 * amin - amaj);
      steps_left = CNT_W'(amaj + 1);
      while (steps_left != 0) begin
        steps_left = steps_left - 1'b1;
        p.pixel_x = cur_x;
        p.pixel_y = cur_y;
        p.last_pixel = (steps_left == 0);
        pending_pixels.push_back(p);
        if (steps_left != 0) begin
          if (x_major) begin
            cur_x = cur_x + 1'b1;
            if (err_term >= 0) begin
              cur_y = minor_up ? cur_y + 1'b1 : cur_y - 1'b1;
            end
          end else begin
            cur_y = cur_y + 1'b1;
            if (err_term >= 0) begin
              cur_x = minor_up ? cur_x + 1'b1 : cur_x - 1'b1;
            end
          end
          err_term = (err_term >= 0) ? ERR_W'(err_term + 2 * (amin - amaj))
                                     : ERR_W'(err_term + 2 * amin);
        end
      end
    endfunction

    function void match_pixel(pix_t got);
      pix_t want;
      if (pending_pixels.size() == 0) begin
        $error("pixel beat with none expected: x=%0d y=%0d last=%0b",
               got.pixel_x, got.pixel_y, got.last_pixel);
        mismatch_count++;
        return;
      end
      want = pending_pixels.pop_front();
      if (got.pixel_x !== want.pixel_x) begin
        $error("pixel_x: expected %0d, got %0d", want.pixel_x, got.pixel_x);
        mismatch_count++;
      end
      if (got.pixel_y !== want.pixel_y) begin
        $error("pixel_y: expected %0d, got %0d", want.pixel_y, got.pixel_y);
        mismatch_count++;
      end
      if (got.last_pixel !== want.last_pixel) begin
        $error("last_pixel: expected %0b, got %0b", want.last_pixel, got.last_pixel);
        mismatch_count++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic seg_valid;
  logic seg_stall;
  seg_t seg;
  logic pix_valid;
  logic pix_stall = 1'b0;
  pix_t pix;

  // Percent chances of a sender gap and of a receiver stall on a given
  // cycle. The main sequence changes them from phase to phase.
  int   send_gap_pct = 0;
  int   pix_hold_pct = 0;
  // Raised once by the main sequence to request one long receiver hold-off.
  logic hold_off_go = 1'b0;

  raster_tracker tracker;

  line_pixel_rasterizer #(
    .TILE_SIZE(TILE)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .seg_valid(seg_valid),
    .seg_stall(seg_stall),
    .seg      (seg),
    .pix_valid(pix_valid),
    .pix_stall(pix_stall),
    .pix      (pix)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop in case the block hangs. The slowest legal run, with every
  // line a full 64 pixels and heavy stalls, ends well inside this bound.
  initial begin
    #3_200_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver side. The stall is driven once per falling edge. When the long
  // hold-off is requested, the stall is held high by a countdown kept here,
  // so the walker and its job queue fill and the block has to stall its
  // segment input while the sender keeps offering beats.
  int  hold_left = 0;
  bit  hold_used = 1'b0;
  always @(negedge clk) begin
    if (hold_off_go && !hold_used) begin
      hold_used = 1'b1;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      pix_stall <= 1'b1;
    end else begin
      pix_stall <= ($urandom_range(99) < pix_hold_pct);
    end
  end

  // Output monitor. Values read right after the rising edge are the ones
  // the block saw at that edge, so a beat counts exactly when taken.
  always @(posedge clk) begin
    if (!rst && pix_valid && !pix_stall) begin
      tracker.match_pixel(pix);
    end
  end

  // Offer one segment beat and hold it until it is taken. The task starts
  // and ends at a falling edge; each step writes seg_valid at most once, so
  // back-to-back beats keep valid high without a glitch.
  task automatic send_segment(seg_t s);
    while ($urandom_range(99) < send_gap_pct) begin
      seg_valid <= 1'b0;
      @(negedge clk);
    end
    seg_valid <= 1'b1;
    seg <= s;
    do @(posedge clk); while (seg_stall);
    tracker.take_segment(s);
    @(negedge clk);
  endtask

  task automatic send_line(int x1, int y1, int x2, int y2);
    seg_t s;
    s.start_x = COORD_W'(x1);
    s.start_y = COORD_W'(y1);
    s.end_x = COORD_W'(x2);
    s.end_y = COORD_W'(y2);
    send_segment(s);
  endtask

  function automatic int near_coord(int base, int span);
    int v;
    v = base + int'($urandom_range(2 * span)) - span;
    return (v < 0) ? 0 : (v > TILE - 1) ? TILE - 1 : v;
  endfunction

  // Mostly short lines keep the run quick; a share of full-range lines,
  // axis-aligned lines and single points keeps the long walks and the
  // flat cases in play.
  task automatic send_random_line();
    int x1, y1, x2, y2;
    int pick;
    pick = $urandom_range(99);
    x1 = $urandom_range(TILE - 1);
    y1 = $urandom_range(TILE - 1);
    if (pick < 55) begin
      x2 = near_coord(x1, 8);
      y2 = near_coord(y1, 8);
    end else if (pick < 85) begin
      x2 = $urandom_range(TILE - 1);
      y2 = $urandom_range(TILE - 1);
    end else if (pick < 91) begin
      x2 = $urandom_range(TILE - 1);
      y2 = y1;
    end else if (pick < 97) begin
      x2 = x1;
      y2 = $urandom_range(TILE - 1);
    end else begin
      x2 = x1;
      y2 = y1;
    end
    send_line(x1, y1, x2, y2);
  endtask

  initial begin
    tracker = new();
    rst = 1'b1;
    seg_valid = 1'b0;
    seg = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed lines, sent with no idling on either side. They cover the
    // corners of the tile, single points, flat lines in both directions,
    // both diagonals, the |dx| = |dy| tie that goes to y, and steep and
    // shallow lines with the minor axis climbing and falling.
    send_line(0, 0, 0, 0);
    send_line(63, 63, 63, 63);
    send_line(0, 5, 63, 5);
    send_line(63, 10, 0, 10);
    send_line(7, 0, 7, 63);
    send_line(40, 63, 40, 0);
    send_line(0, 0, 63, 63);
    send_line(63, 63, 0, 0);
    send_line(63, 0, 0, 63);
    send_line(0, 63, 63, 0);
    send_line(10, 10, 20, 20);
    send_line(20, 10, 10, 20);
    send_line(0, 0, 63, 20);
    send_line(63, 20, 0, 0);
    send_line(0, 40, 63, 2);
    send_line(5, 0, 30, 63);
    send_line(50, 0, 12, 63);
    send_line(30, 30, 31, 30);
    send_line(30, 30, 30, 31);
    send_line(30, 30, 31, 31);
    send_line(63, 0, 0, 0);
    send_line(0, 63, 0, 0);

    // Random lines, first with no idling but with one long receiver
    // hold-off so the block backs up into its input.
    hold_off_go <= 1'b1;
    repeat (40) send_random_line();

    // Sender mostly idle.
    send_gap_pct = 77;
    pix_hold_pct = 0;
    repeat (40) send_random_line();

    // Receiver mostly stalled.
    send_gap_pct = 0;
    pix_hold_pct = 77;
    repeat (40) send_random_line();

    // Light idling on both sides.
    send_gap_pct = 10;
    pix_hold_pct = 10;
    repeat (40) send_random_line();

    seg_valid <= 1'b0;

    // Drain the remaining pixels, then give the block a full line time to
    // show any stray beat.
    while (tracker.pending_pixels.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    if (tracker.mismatch_count == 0 && tracker.pending_pixels.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: line_pixel_rasterizer.f
src/lpr_pkg.sv
src/lpr_front.sv
src/lpr_queue.sv
src/lpr_back.sv
src/line_pixel_rasterizer.sv
verif/tb_top.sv
